/* rtl/ncis_pkg.sv */
// ----------------------------------------------------------------------------
// ncis_pkg
// Shared types, opcode codes and tables of the 4-bit instruction step core.
// ----------------------------------------------------------------------------
package ncis_pkg;

   localparam int STACK_DEPTH = 3;

   // Opcode high nibble
   localparam logic [3:0] HI_NOP     = 4'h0;
   localparam logic [3:0] HI_JCN     = 4'h1;
   localparam logic [3:0] HI_FIM_SRC = 4'h2;
   localparam logic [3:0] HI_FIN_JIN = 4'h3;
   localparam logic [3:0] HI_JUN     = 4'h4;
   localparam logic [3:0] HI_JMS     = 4'h5;
   localparam logic [3:0] HI_INC     = 4'h6;
   localparam logic [3:0] HI_ISZ     = 4'h7;
   localparam logic [3:0] HI_ADD     = 4'h8;
   localparam logic [3:0] HI_SUB     = 4'h9;
   localparam logic [3:0] HI_LD      = 4'hA;
   localparam logic [3:0] HI_XCH     = 4'hB;
   localparam logic [3:0] HI_BBL     = 4'hC;
   localparam logic [3:0] HI_LDM     = 4'hD;
   localparam logic [3:0] HI_IO      = 4'hE;
   localparam logic [3:0] HI_ACC     = 4'hF;

   // I/O and RAM group, low nibble
   localparam logic [3:0] IO_WRM = 4'h0;
   localparam logic [3:0] IO_WMP = 4'h1;
   localparam logic [3:0] IO_WRR = 4'h2;
   localparam logic [3:0] IO_WPM = 4'h3;
   localparam logic [3:0] IO_WR0 = 4'h4;
   localparam logic [3:0] IO_WR1 = 4'h5;
   localparam logic [3:0] IO_WR2 = 4'h6;
   localparam logic [3:0] IO_WR3 = 4'h7;
   localparam logic [3:0] IO_SBM = 4'h8;
   localparam logic [3:0] IO_RDM = 4'h9;
   localparam logic [3:0] IO_RDR = 4'hA;
   localparam logic [3:0] IO_ADM = 4'hB;
   localparam logic [3:0] IO_RD0 = 4'hC;
   localparam logic [3:0] IO_RD1 = 4'hD;
   localparam logic [3:0] IO_RD2 = 4'hE;
   localparam logic [3:0] IO_RD3 = 4'hF;

   // Accumulator group, low nibble
   localparam logic [3:0] AC_CLB = 4'h0;
   localparam logic [3:0] AC_CLC = 4'h1;
   localparam logic [3:0] AC_IAC = 4'h2;
   localparam logic [3:0] AC_CMC = 4'h3;
   localparam logic [3:0] AC_CMA = 4'h4;
   localparam logic [3:0] AC_RAL = 4'h5;
   localparam logic [3:0] AC_RAR = 4'h6;
   localparam logic [3:0] AC_TCC = 4'h7;
   localparam logic [3:0] AC_DAC = 4'h8;
   localparam logic [3:0] AC_TCS = 4'h9;
   localparam logic [3:0] AC_STC = 4'hA;
   localparam logic [3:0] AC_DAA = 4'hB;
   localparam logic [3:0] AC_KBP = 4'hC;
   localparam logic [3:0] AC_DCL = 4'hD;

   // Conditional jump condition bits
   localparam logic [3:0] JCN_INVERT   = 4'b1000;
   localparam logic [3:0] JCN_ACC_ZERO = 4'b0100;
   localparam logic [3:0] JCN_CARRY    = 4'b0010;
   localparam logic [3:0] JCN_TEST     = 4'b0001;

   // Port write kinds
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_RAM  = 2'd1;
   localparam logic [1:0] KIND_ROM  = 2'd2;

   // Status nibble that stops the core: bank 0, chip 3, register 3, nibble 0
   localparam logic [3:0] HALT_CHIP_REG = 4'hF;
   localparam logic [3:0] DEC_TEN       = 4'd10;
   localparam logic [3:0] DEC_NINE      = 4'd9;
   localparam logic [3:0] NIBBLE_MAX    = 4'hF;

   typedef struct packed {
      logic        clear_we;
      logic [11:0] clear_addr;
      logic        take_item;
      logic        fetch_op;
      logic        latch_op;
      logic        fetch_b2;
      logic        latch_b2;
      logic        commit;
   } cmd_type;

   typedef struct packed {
      logic runs;
      logic needs_b2;
      logic halted;
   } sts_type;

   // Keyboard code: 0..4 pass through, anything else is all ones
   function automatic logic [3:0] kbp_code(input logic [3:0] a);
      logic [3:0] r;
      unique case (a)
         4'h0: r = 4'h0;
         4'h1: r = 4'h1;
         4'h2: r = 4'h2;
         4'h3: r = 4'h3;
         4'h4: r = 4'h4;
         default: r = NIBBLE_MAX;
      endcase
      return r;
   endfunction

endpackage

/* rtl/ncis_if.sv */
// ----------------------------------------------------------------------------
// ncis_req_if / ncis_rsp_if
// Valid/ready channels carrying request and response items of the core.
// ----------------------------------------------------------------------------
interface ncis_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [11:0] load_address;
   logic [7:0]  load_byte;
   logic        test_pin;
   logic [3:0]  rom_port_in;

   modport source (output valid, mode, load_address, load_byte, test_pin, rom_port_in,
                   input ready);
   modport sink (input valid, mode, load_address, load_byte, test_pin, rom_port_in,
                 output ready);
endinterface

interface ncis_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] program_counter;
   logic [3:0]  accumulator;
   logic        carry_flag;
   logic [1:0]  port_write_kind;
   logic [4:0]  port_index;
   logic [3:0]  port_value;
   logic        halted;
   logic        bad_opcode;

   modport source (output valid, program_counter, accumulator, carry_flag, port_write_kind,
                   port_index, port_value, halted, bad_opcode, input ready);
   modport sink (input valid, program_counter, accumulator, carry_flag, port_write_kind,
                 port_index, port_value, halted, bad_opcode, output ready);
endinterface

/* rtl/ncis_ctrl.sv */
// ----------------------------------------------------------------------------
// ncis_ctrl
// Sequencer: clearing pass, fetch of opcode and second byte, commit.
// ----------------------------------------------------------------------------
module ncis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  ncis_pkg::sts_type sts,
   output ncis_pkg::cmd_type cmd
);
   import ncis_pkg::*;

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_OP, ST_B2, ST_EXEC} state_type;

   state_type   state_ff, state_in;
   logic [11:0] clr_cnt_ff, clr_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      cmd           = '0;
      cmd.clear_we  = (state_ff == ST_CLEAR);
      cmd.clear_addr = clr_cnt_ff;
      cmd.take_item = (state_ff == ST_IDLE) && req_valid;
      cmd.fetch_op  = cmd.take_item && sts.runs;
      cmd.latch_op  = (state_ff == ST_OP);
      cmd.fetch_b2  = (state_ff == ST_OP) && sts.needs_b2;
      cmd.latch_b2  = (state_ff == ST_B2);
      cmd.commit    = (state_ff == ST_EXEC) && out_free;
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = rsp_valid_ff;

      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 12'd1;
            if (&clr_cnt_ff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd.take_item) state_in = sts.runs ? ST_OP : ST_EXEC;
         end
         ST_OP:   state_in = sts.needs_b2 ? ST_B2 : ST_EXEC;
         ST_B2:   state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd.commit) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      priority if (cmd.commit) rsp_valid_in = 1'b1;
      else if (rsp_ready)      rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/ncis_dp.sv */
// ----------------------------------------------------------------------------
// ncis_dp
// Datapath: program store, RAM data and status, registers, execute logic.
// ----------------------------------------------------------------------------
module ncis_dp #(
   parameter int RAM_BANKS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  ncis_pkg::cmd_type cmd,
   output ncis_pkg::sts_type sts,
   input  logic              req_mode,
   input  logic [11:0]       req_load_address,
   input  logic [7:0]        req_load_byte,
   input  logic              req_test_pin,
   input  logic [3:0]        req_rom_port_in,
   output logic [11:0]       rsp_program_counter,
   output logic [3:0]        rsp_accumulator,
   output logic              rsp_carry_flag,
   output logic [1:0]        rsp_port_write_kind,
   output logic [4:0]        rsp_port_index,
   output logic [3:0]        rsp_port_value,
   output logic              rsp_halted,
   output logic              rsp_bad_opcode
);
   import ncis_pkg::*;

   localparam int DATA_DEPTH = RAM_BANKS * 256;
   localparam int STAT_DEPTH = RAM_BANKS * 64;
   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int SAW = $clog2(STAT_DEPTH);
   localparam logic [3:0] BANKS_L = 4'(RAM_BANKS);

   function automatic logic is_two_byte(input logic [7:0] op);
      logic r;
      r = (op[7:4] == HI_JCN) || (op[7:4] == HI_JUN) || (op[7:4] == HI_JMS) ||
          (op[7:4] == HI_ISZ) || ((op[7:4] == HI_FIM_SRC) && !op[0]);
      return r;
   endfunction

   function automatic logic is_fin(input logic [7:0] op);
      logic r;
      r = (op[7:4] == HI_FIN_JIN) && !op[0];
      return r;
   endfunction

   // Memories
   logic [7:0] prog_mem [4096];
   logic [3:0] data_mem [DATA_DEPTH];
   logic [3:0] stat_mem [STAT_DEPTH];

   // Item and fetch registers
   logic        item_mode_ff, item_run_ff, item_test_ff;
   logic [11:0] item_addr_ff;
   logic [7:0]  item_byte_ff;
   logic [3:0]  item_port_ff;
   logic [7:0]  op_ff, b2_ff, prog_rd_ff;
   logic [3:0]  data_rd_ff, stat_rd_ff;

   // Architectural state
   logic [3:0]  iregs_ff [16];
   logic [3:0]  acc_ff, acc_in;
   logic        cy_ff, cy_in;
   logic [11:0] pc_ff, pc_in;
   logic [11:0] stack_ff [STACK_DEPTH];
   logic [11:0] stack_in [STACK_DEPTH];
   logic [7:0]  src_ff, src_in;
   logic [2:0]  bank_ff, bank_in;
   logic        halt_ff, halt_in;
   logic [3:0]  shadow_ff, shadow_in;

   // Response registers
   logic [11:0] out_pc_ff;
   logic [3:0]  out_acc_ff, out_pval_ff;
   logic        out_cy_ff, out_halt_ff, out_bad_ff;
   logic [1:0]  out_kind_ff;
   logic [4:0]  out_pidx_ff;

   // Execute signals
   logic [3:0]  op_hi, lo, cur, add_b, mem_d, mem_s, ireg_d;
   logic [11:0] pc1, pc2, pc_seq;
   logic [7:0]  pair_v, pair0, pair_d;
   logic        present, ireg_we, pair_we, data_we, stat_we, bad_x, add_en, add_c, cond;
   logic [1:0]  kind_x;
   logic [4:0]  pidx_x;
   logic [3:0]  pval_x;
   logic [4:0]  sum5, daa5;
   logic        run_c, stat_hit;
   logic [1:0]  st_sel;

   // Memory port controls
   logic        prog_we;
   logic [11:0] prog_waddr, prog_raddr;
   logic [7:0]  prog_wdata;
   logic        dmem_we, smem_we;
   logic [DAW-1:0] daddr_w, daddr_r;
   logic [SAW-1:0] saddr_w, saddr_r;

   always_comb begin
      sts.runs     = req_mode && !halt_ff;
      sts.needs_b2 = is_two_byte(prog_rd_ff) || is_fin(prog_rd_ff);
      sts.halted   = halt_ff;
   end

   // Execute one instruction from op_ff / b2_ff
   always_comb begin
      op_hi   = op_ff[7:4];
      lo      = op_ff[3:0];
      pc1     = pc_ff + 12'd1;
      pc2     = pc_ff + 12'd2;
      pc_seq  = is_two_byte(op_ff) ? pc2 : pc1;
      cur     = iregs_ff[lo];
      pair_v  = {iregs_ff[{lo[3:1], 1'b0}], iregs_ff[{lo[3:1], 1'b1}]};
      pair0   = {iregs_ff[0], iregs_ff[1]};
      present = {1'b0, bank_ff} < BANKS_L;
      mem_d   = present ? data_rd_ff : '0;
      mem_s   = present ? stat_rd_ff : '0;

      acc_in  = acc_ff;
      cy_in   = cy_ff;
      pc_in   = pc_seq;
      src_in  = src_ff;
      bank_in = bank_ff;
      for (int i = 0; i < STACK_DEPTH; i++) stack_in[i] = stack_ff[i];
      ireg_we = 1'b0;
      pair_we = 1'b0;
      ireg_d  = cur;
      pair_d  = b2_ff;
      data_we = 1'b0;
      stat_we = 1'b0;
      kind_x  = KIND_NONE;
      pidx_x  = '0;
      pval_x  = '0;
      bad_x   = 1'b0;
      add_en  = 1'b0;
      add_b   = cur;
      add_c   = cy_ff;
      cond    = 1'b0;
      sum5    = '0;
      daa5    = {1'b0, acc_ff};

      unique case (op_hi)
         HI_NOP: bad_x = (lo != '0);
         HI_JCN: begin
            cond = ((|(lo & JCN_ACC_ZERO)) && (acc_ff == '0)) ||
                   ((|(lo & JCN_CARRY)) && cy_ff) ||
                   ((|(lo & JCN_TEST)) && !item_test_ff);
            if (|(lo & JCN_INVERT)) cond = !cond;
            if (cond) pc_in = {pc_seq[11:8], b2_ff};
         end
         HI_FIM_SRC: begin
            if (!lo[0]) pair_we = 1'b1;
            else        src_in  = pair_v;
         end
         HI_FIN_JIN: begin
            if (!lo[0]) pair_we = 1'b1;
            else        pc_in   = {pc_seq[11:8], pair_v};
         end
         HI_JUN: pc_in = {lo, b2_ff};
         HI_JMS: begin
            for (int i = 1; i < STACK_DEPTH; i++) stack_in[i] = stack_ff[i-1];
            stack_in[0] = pc_seq;
            pc_in = {lo, b2_ff};
         end
         HI_INC: begin
            ireg_we = 1'b1;
            ireg_d  = cur + 4'd1;
         end
         HI_ISZ: begin
            ireg_we = 1'b1;
            ireg_d  = cur + 4'd1;
            if (ireg_d != '0) pc_in = {pc_seq[11:8], b2_ff};
         end
         HI_ADD: add_en = 1'b1;
         HI_SUB: begin
            add_en = 1'b1;
            add_b  = ~cur;
            add_c  = !cy_ff;
         end
         HI_LD:  acc_in = cur;
         HI_XCH: begin
            acc_in  = cur;
            ireg_we = 1'b1;
            ireg_d  = acc_ff;
         end
         HI_BBL: begin
            pc_in = stack_ff[0];
            for (int i = 0; i < STACK_DEPTH - 1; i++) stack_in[i] = stack_ff[i+1];
            stack_in[STACK_DEPTH-1] = '0;
            acc_in = lo;
         end
         HI_LDM: acc_in = lo;
         HI_IO: begin
            unique case (lo)
               IO_WRM: data_we = present;
               IO_WMP: begin
                  if (present) begin
                     kind_x = KIND_RAM;
                     pidx_x = {bank_ff, src_ff[7:6]};
                     pval_x = acc_ff;
                  end
               end
               IO_WRR: begin
                  kind_x = KIND_ROM;
                  pidx_x = {1'b0, src_ff[7:4]};
                  pval_x = acc_ff;
               end
               IO_WPM: ;
               IO_WR0, IO_WR1, IO_WR2, IO_WR3: stat_we = present;
               IO_SBM: begin
                  add_en = 1'b1;
                  add_b  = ~mem_d;
                  add_c  = !cy_ff;
               end
               IO_RDM: acc_in = mem_d;
               IO_RDR: acc_in = item_port_ff;
               IO_ADM: begin
                  add_en = 1'b1;
                  add_b  = mem_d;
               end
               IO_RD0, IO_RD1, IO_RD2, IO_RD3: acc_in = mem_s;
               default: ;
            endcase
         end
         HI_ACC: begin
            unique case (lo)
               AC_CLB: begin acc_in = '0; cy_in = 1'b0; end
               AC_CLC: cy_in = 1'b0;
               AC_IAC: begin
                  acc_in = acc_ff + 4'd1;
                  cy_in  = (acc_in == '0);
               end
               AC_CMC: cy_in = !cy_ff;
               AC_CMA: acc_in = ~acc_ff;
               AC_RAL: begin
                  acc_in = {acc_ff[2:0], cy_ff};
                  cy_in  = acc_ff[3];
               end
               AC_RAR: begin
                  acc_in = {cy_ff, acc_ff[3:1]};
                  cy_in  = acc_ff[0];
               end
               AC_TCC: begin acc_in = {3'b000, cy_ff}; cy_in = 1'b0; end
               AC_DAC: begin
                  acc_in = acc_ff + NIBBLE_MAX;
                  cy_in  = (acc_in != NIBBLE_MAX);
               end
               AC_TCS: begin acc_in = cy_ff ? DEC_TEN : DEC_NINE; cy_in = 1'b0; end
               AC_STC: cy_in = 1'b1;
               AC_DAA: begin
                  if (cy_ff || (acc_ff > DEC_NINE)) daa5 = {1'b0, acc_ff} + 5'd6;
                  acc_in = daa5[3:0];
                  if (daa5[4]) cy_in = 1'b1;
               end
               AC_KBP: acc_in = kbp_code(acc_ff);
               AC_DCL: bank_in = acc_ff[2:0];
               default: bad_x = 1'b1;
            endcase
         end
         default: bad_x = 1'b1;
      endcase

      if (add_en) begin
         sum5   = {1'b0, acc_ff} + {1'b0, add_b} + {4'b0000, add_c};
         acc_in = sum5[3:0];
         cy_in  = sum5[4];
      end

      stat_hit  = stat_we && (bank_ff == '0) && (src_ff[7:4] == HALT_CHIP_REG) &&
                  (lo[1:0] == 2'b00);
      shadow_in = stat_hit ? acc_ff : shadow_ff;
      halt_in   = halt_ff || bad_x || (shadow_in == 4'd1);
      run_c     = cmd.commit && item_run_ff;
   end

   // Memory addressing: clearing pass, load, fetch, RAM access
   always_comb begin
      prog_we    = cmd.clear_we || (cmd.commit && !item_mode_ff);
      prog_waddr = cmd.clear_we ? cmd.clear_addr : item_addr_ff;
      prog_wdata = cmd.clear_we ? 8'h00 : item_byte_ff;
      priority if (cmd.fetch_op) prog_raddr = pc_ff;
      else if (is_fin(prog_rd_ff)) prog_raddr = {pc_ff[11:8] + {3'b000, &pc_ff[7:0]}, pair0};
      else prog_raddr = pc_ff + 12'd1;

      st_sel  = cmd.latch_op ? prog_rd_ff[1:0] : op_ff[1:0];
      daddr_r = DAW'({bank_ff, src_ff});
      saddr_r = SAW'({bank_ff, src_ff[7:4], st_sel});
      dmem_we = (cmd.clear_we && (cmd.clear_addr < 12'(DATA_DEPTH))) || (run_c && data_we);
      smem_we = (cmd.clear_we && (cmd.clear_addr < 12'(STAT_DEPTH))) || (run_c && stat_we);
      daddr_w = cmd.clear_we ? DAW'(cmd.clear_addr) : daddr_r;
      saddr_w = cmd.clear_we ? SAW'(cmd.clear_addr) : SAW'({bank_ff, src_ff[7:4], op_ff[1:0]});
   end

   always_ff @(posedge clock) begin
      if (prog_we) prog_mem[prog_waddr] <= prog_wdata;
      if (cmd.fetch_op || cmd.fetch_b2) prog_rd_ff <= prog_mem[prog_raddr];
   end

   always_ff @(posedge clock) begin
      if (dmem_we) data_mem[daddr_w] <= cmd.clear_we ? 4'h0 : acc_ff;
      data_rd_ff <= data_mem[daddr_r];
   end

   always_ff @(posedge clock) begin
      if (smem_we) stat_mem[saddr_w] <= cmd.clear_we ? 4'h0 : acc_ff;
      stat_rd_ff <= stat_mem[saddr_r];
   end

   // Item capture and fetched bytes
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_mode_ff <= req_mode;
         item_run_ff  <= req_mode && !halt_ff;
         item_addr_ff <= req_load_address;
         item_byte_ff <= req_load_byte;
         item_test_ff <= req_test_pin;
         item_port_ff <= req_rom_port_in;
      end
      if (cmd.latch_op) op_ff <= prog_rd_ff;
      if (cmd.latch_b2) b2_ff <= prog_rd_ff;
   end

   // Architectural state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) iregs_ff[i] <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= '0;
         acc_ff    <= '0;
         cy_ff     <= 1'b0;
         pc_ff     <= '0;
         src_ff    <= '0;
         bank_ff   <= '0;
         halt_ff   <= 1'b0;
         shadow_ff <= '0;
      end else if (run_c) begin
         for (int i = 0; i < 16; i++) begin
            if (pair_we && (4'(i) >> 1) == {1'b0, lo[3:1]})
               iregs_ff[i] <= i[0] ? pair_d[3:0] : pair_d[7:4];
            else if (ireg_we && 4'(i) == lo)
               iregs_ff[i] <= ireg_d;
         end
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= stack_in[i];
         acc_ff    <= acc_in;
         cy_ff     <= cy_in;
         pc_ff     <= pc_in;
         src_ff    <= src_in;
         bank_ff   <= bank_in;
         halt_ff   <= halt_in;
         shadow_ff <= shadow_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_pc_ff   <= item_run_ff ? pc_in : pc_ff;
         out_acc_ff  <= item_run_ff ? acc_in : acc_ff;
         out_cy_ff   <= item_run_ff ? cy_in : cy_ff;
         out_kind_ff <= item_run_ff ? kind_x : KIND_NONE;
         out_pidx_ff <= item_run_ff ? pidx_x : '0;
         out_pval_ff <= item_run_ff ? pval_x : '0;
         out_halt_ff <= item_run_ff ? halt_in : halt_ff;
         out_bad_ff  <= item_run_ff && bad_x;
      end
   end

   assign rsp_program_counter = out_pc_ff;
   assign rsp_accumulator     = out_acc_ff;
   assign rsp_carry_flag      = out_cy_ff;
   assign rsp_port_write_kind = out_kind_ff;
   assign rsp_port_index      = out_pidx_ff;
   assign rsp_port_value      = out_pval_ff;
   assign rsp_halted          = out_halt_ff;
   assign rsp_bad_opcode      = out_bad_ff;

endmodule

/* rtl/nibble_cpu_instruction_step_core.sv */
// ----------------------------------------------------------------------------
// nibble_cpu_instruction_step_core
// 4-bit instruction step core: loads program bytes, runs one instruction per
// step item and reports program counter, accumulator, carry and port writes.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass over all 4096 program addresses
// that zeroes the program store, the RAM data and the RAM status nibbles; no
// item is taken during it. Items are then handled one at a time. A load item,
// or a step item on a halted core, goes from idle straight to execute, where
// its result is committed into the output register. A one-byte instruction
// passes the idle, opcode and execute states; a two-byte instruction or FIN
// also passes the second-byte state between opcode and execute: the
// program store has a single registered read port, so the opcode and the
// second byte (or the FIN table byte) are read in successive cycles before
// execute. RAM data and status are read in the same cycles, so read-modify
// instructions add nothing. The result sits in an output register; the next
// item is accepted while it waits, but its own result is held in execute
// until that register is taken. The core halts on an unknown opcode or when
// status nibble 0 of bank 0, chip 3, register 3 is written with 1; later step
// items change nothing and report no port write, while loads still work.
// ----------------------------------------------------------------------------
module nibble_cpu_instruction_step_core #(
   parameter int RAM_BANKS = 8
) (
   input logic         clock,
   input logic         reset,
   ncis_req_if.sink    req_ch,
   ncis_rsp_if.source  rsp_ch
);
   import ncis_pkg::*;

   cmd_type dp_cmd;
   sts_type dp_sts;

   // Sequencer: clearing pass, fetch cycles, commit into the output register
   ncis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   // Memories, register file, ALU and the response payload
   ncis_dp #(
      .RAM_BANKS (RAM_BANKS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (dp_cmd),
      .sts                 (dp_sts),
      .req_mode            (req_ch.mode),
      .req_load_address    (req_ch.load_address),
      .req_load_byte       (req_ch.load_byte),
      .req_test_pin        (req_ch.test_pin),
      .req_rom_port_in     (req_ch.rom_port_in),
      .rsp_program_counter (rsp_ch.program_counter),
      .rsp_accumulator     (rsp_ch.accumulator),
      .rsp_carry_flag      (rsp_ch.carry_flag),
      .rsp_port_write_kind (rsp_ch.port_write_kind),
      .rsp_port_index      (rsp_ch.port_index),
      .rsp_port_value      (rsp_ch.port_value),
      .rsp_halted          (rsp_ch.halted),
      .rsp_bad_opcode      (rsp_ch.bad_opcode)
   );

   // Once stopped, the core stays stopped until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(dp_sts.halted))
      else $error("halt state dropped");

   // No item is taken while the clearing pass writes the memories
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> !dp_cmd.clear_we)
      else $error("item accepted during clearing pass");

   // A commit never overwrites a result that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwritten");

   // An unknown opcode always reports a halted core
   a_bad_halts: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.bad_opcode) |-> rsp_ch.halted)
      else $error("bad opcode without halt");

endmodule
